// ----- rtl/core/sphkd_pkg.sv -----
// Package for the SPH kernel density accumulator.
// Holds payload structs and fixed constants; no dependencies.
package sphkd_pkg;

  // Width of a position coordinate; the difference is formed one bit wider.
  localparam int CoordWidth = 32;

  typedef struct packed {
    logic signed [CoordWidth-1:0] self_position;
    logic        [30:0]           self_smoothing;
    logic signed [CoordWidth-1:0] neighbor_position;
    logic        [30:0]           neighbor_smoothing;
    logic                         last_neighbor;
  } sphkd_in_t;

  typedef struct packed {
    logic        [31:0] kernel_value;
    logic signed [31:0] kernel_gradient;
    logic        [31:0] density;
    logic               density_done;
  } sphkd_out_t;

  localparam logic [31:0] MassReset = 32'd65536;
  localparam logic [63:0] OneQ30    = 64'd1 << 30;
  localparam logic [63:0] TwoQ30    = 64'd1 << 31;
  localparam logic [47:0] SumMax    = 48'hFFFF_FFFF_FFFF;

endpackage

// ----- rtl/core/sph_kernel_density_accumulator_top.sv -----
// Top level of the SPH kernel density accumulator.
// Uses sphkd_pkg and the shared sphkd_divider.
//
// Each input transfer carries one particle pair. The block forms the
// distance and, for each of the two smoothing lengths, evaluates the 1-D
// M4 cubic-spline kernel and gradient, averages both sides and adds mass
// times kernel into a 48-bit saturating density sum, which is reported
// with every result and cleared after a pair marked as the last neighbor.
// One 32x32 multiplier and one bit-serial 64-bit divider are shared under
// a sequencer; the divider sets the rate. With both sides in reach of the
// kernel a pair goes per side through three divisions (start, quotient
// bits and done cycle) and six other steps, then through the mass,
// accumulate, output and idle steps. A side out of reach or with a zero
// smoothing length passes only through S_SIDE and S_NEXT. in_ready_o is
// low while a pair is in flight. The result sits in an output register;
// the next pair is taken once it has been transferred. particle_mass may
// be written while the block is idle.
module sph_kernel_density_accumulator_top import sphkd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  sphkd_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output sphkd_out_t out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_SIDE, S_QDIV, S_QWAIT, S_X2, S_X3, S_POLY, S_WDIV, S_WWAIT,
    S_HH, S_GDIV, S_GWAIT, S_NEXT, S_MASS, S_ACC, S_OUT
  } state_e;

  state_e      state_q;
  logic [31:0] mass_q;
  logic [47:0] sum_q;
  logic [63:0] d_q, h_q, x_q, x2_q, x3_q, f_q, g_q, hh_q, prod_q;
  logic [63:0] wsum_q, gsum_q;
  logic        side_q;
  logic [1:0]  sgn_q;
  logic        last_q, inner_q;
  logic [30:0] hn_q;
  sphkd_out_t  res_q;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // Shared divider.
  logic        div_start, div_done;
  logic [63:0] div_num, div_den, div_quo;
  sphkd_divider u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_num), .divisor_i(div_den),
    .done_o(div_done), .quotient_o(div_quo)
  );

  // Sign-extended position difference, one bit wider than a coordinate.
  logic signed [CoordWidth-1:0] xs_c, xn_c;
  logic signed [CoordWidth:0]   diff;
  assign xs_c = in_data_i.self_position;
  assign xn_c = in_data_i.neighbor_position;
  assign diff = (CoordWidth+1)'(xs_c) - (CoordWidth+1)'(xn_c);

  logic [63:0] poly_f, poly_g;
  always_comb begin
    if (inner_q) begin
      poly_f = OneQ30 + ((64'd3 * x3_q) >> 2) - ((64'd3 * x2_q) >> 1);
      poly_g = 64'd3 * x_q - ((64'd9 * x2_q) >> 2);
    end else begin
      poly_f = x3_q >> 2;
      poly_g = (64'd3 * x2_q) >> 2;
    end
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_q)
      S_X2:  begin mul_a = x_q[31:0];  mul_b = x_q[31:0]; end
      S_X3:  begin mul_a = x2_q[31:0]; mul_b = x_q[31:0]; end
      S_HH:  begin mul_a = h_q[31:0];  mul_b = h_q[31:0]; end
      S_MASS: begin mul_a = mass_q;    mul_b = res_q.kernel_value; end
      S_QDIV: begin div_start = 1'b1; div_num = d_q << 30; div_den = h_q; end
      S_WDIV: begin div_start = 1'b1; div_num = f_q << 3; div_den = 64'd3 * h_q; end
      S_GDIV: begin div_start = 1'b1; div_num = g_q << 19; div_den = 64'd3 * hh_q; end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = res_q;
  assign cfg_ready_o = 1'b1;

  logic [63:0] wavg, gavg;
  logic [48:0] acc;
  assign wavg = wsum_q >> 1;
  assign gavg = gsum_q >> 1;
  // The mass product shifted down by 16 spans the full 48 bits of the sum.
  assign acc  = {1'b0, sum_q} + {1'b0, prod_q[63:16]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mass_q  <= MassReset;
      sum_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        mass_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SIDE;
          end
        end
        S_SIDE: begin
          if (h_q == 64'd0 || d_q > (h_q << 1)) begin
            state_q <= S_NEXT;
          end else begin
            state_q <= S_QDIV;
          end
        end
        S_QDIV:  state_q <= S_QWAIT;
        S_QWAIT: if (div_done) begin state_q <= S_X2; end
        S_X2:    state_q <= S_X3;
        S_X3:    state_q <= S_POLY;
        S_POLY:  state_q <= S_WDIV;
        S_WDIV:  state_q <= S_WWAIT;
        S_WWAIT: if (div_done) begin state_q <= S_HH; end
        S_HH:    state_q <= S_GDIV;
        S_GDIV:  state_q <= S_GWAIT;
        S_GWAIT: if (div_done) begin state_q <= S_NEXT; end
        S_NEXT:  state_q <= side_q ? S_MASS : S_SIDE;
        S_MASS:  state_q <= S_ACC;
        S_ACC: begin
          state_q <= S_OUT;
          sum_q   <= acc[48] ? SumMax : acc[47:0];
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
            if (res_q.density_done) begin
              sum_q <= '0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sgn_q  <= (diff == '0) ? 2'b00 : (diff[CoordWidth] ? 2'b11 : 2'b01);
          d_q    <= diff[CoordWidth] ? 64'(-diff) : 64'(diff);
          h_q    <= 64'(in_data_i.self_smoothing);
          hn_q   <= in_data_i.neighbor_smoothing;
          last_q <= in_data_i.last_neighbor;
          side_q <= 1'b0;
          wsum_q <= '0;
          gsum_q <= '0;
        end
      end
      S_SIDE:  inner_q <= (d_q <= h_q);
      S_QWAIT: if (div_done) begin
        x_q <= inner_q ? div_quo : TwoQ30 - div_quo;
      end
      S_X2:    x2_q <= mul_p >> 30;
      S_X3:    x3_q <= mul_p >> 30;
      S_POLY: begin
        f_q <= poly_f;
        g_q <= poly_g;
      end
      S_WWAIT: if (div_done) begin wsum_q <= wsum_q + div_quo; end
      S_HH:    hh_q <= mul_p;
      S_GWAIT: if (div_done) begin
        gsum_q <= gsum_q + ((div_quo > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : div_quo);
      end
      S_NEXT: begin
        side_q <= 1'b1;
        h_q    <= 64'(hn_q);
        res_q.kernel_value <= (wavg > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wavg[31:0];
        res_q.density_done <= last_q;
        begin
          logic [31:0] gm;
          gm = (gavg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : gavg[31:0];
          case (sgn_q)
            2'b01:   res_q.kernel_gradient <= -gm;
            2'b11:   res_q.kernel_gradient <= gm;
            default: res_q.kernel_gradient <= '0;
          endcase
        end
      end
      S_MASS:  prod_q <= mul_p;
      S_ACC: begin
        if (acc[48] || acc[47:32] != '0) begin
          res_q.density <= 32'hFFFF_FFFF;
        end else begin
          res_q.density <= acc[31:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/sphkd_divider.sv -----
// Restoring divider, one quotient bit per cycle, 64-bit operands.
// Depends on nothing but the clock and reset.
module sphkd_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, div_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [65:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    // The shifted remainder can reach 65 bits when the divisor uses bit 63.
    trial  = {1'b0, rem_q, quo_q[63]} - {2'b00, div_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[65]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
